// ===== hw/rtl/utrb_pkg.sv =====
// Shared types and constants for the UART transmit/receive ring buffer.
// Used by the controller, the datapath, the top level and the checker.
package utrb_pkg;

  // Ring sizes.
  localparam int unsigned TX_DEPTH = 1024;
  localparam int unsigned RX_DEPTH = 32;

  // Address widths and counter widths (a counter must hold the depth itself).
  localparam int unsigned TxAw = $clog2(TX_DEPTH);
  localparam int unsigned TxCw = $clog2(TX_DEPTH + 1);
  localparam int unsigned RxAw = $clog2(RX_DEPTH);
  localparam int unsigned RxCw = $clog2(RX_DEPTH + 1);

  // Byte returned by a get on an empty receive ring.
  localparam logic [7:0] EMPTY_BYTE = 8'h00;

  // Event codes.
  typedef enum logic [1:0] {
    MODE_PUT  = 2'd0,
    MODE_DONE = 2'd1,
    MODE_RECV = 2'd2,
    MODE_GET  = 2'd3
  } mode_e;

  // Status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TX_FULL  = 2'd1,
    ST_RX_EMPTY = 2'd2,
    ST_RX_OVER  = 2'd3
  } status_e;

  // Input word.
  typedef struct packed {
    mode_e      mode;
    logic [7:0] data_byte;
  } in_word_t;

  // Output word.
  typedef struct packed {
    logic       line_valid;
    logic [7:0] line_byte;
    logic       read_valid;
    logic [7:0] read_byte;
    status_e    status;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the input word and launch both ring reads
    logic commit;   // apply the event and load the output register
  } ctrl_cmd_t;

endpackage

// ===== hw/rtl/uart_tx_rx_ring_buffer_top.sv =====
// Top level of the UART transmit/receive ring buffer.
// Depends on utrb_pkg, utrb_ctrl and utrb_dpath.
//
//   Channel   Handshake                 Word type
//   input     in_valid_i / in_stall_o   in_word_t  (mode, data_byte)
//   output    out_valid_o / out_stall_i out_word_t (line, read, status)
//
// Each word passes a capture step, which latches it and reads the head of
// both rings, then a commit step, which applies the event and loads the
// output register; the registered ring read keeps a new word out until then.
// After reset both rings are empty; the ring memories need no clearing.
// A stalled output holds the commit cycle until the output register drains.
module uart_tx_rx_ring_buffer_top
  import utrb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  ctrl_cmd_t cmd;

  // Sequencing and output valid.
  utrb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd)
  );

  // Rings, counters and output word.
  utrb_dpath u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .in_word_i (in_word_i),
    .out_word_o(out_word_o)
  );

endmodule

// ===== hw/rtl/utrb_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; used for both rings of the buffer.
module utrb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port; data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hw/rtl/utrb_ctrl.sv =====
// Controller of the ring buffer: accepts a word, sequences the commit and
// owns the output valid flag. Depends on utrb_pkg.
module utrb_ctrl
  import utrb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output ctrl_cmd_t cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  // The output register can take a result when empty or drained this cycle.
  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o.capture = 1'b0;
    cmd_o.commit  = 1'b0;
    state_d       = state_q;
    out_valid_d   = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and registered valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== hw/rtl/utrb_dpath.sv =====
// Datapath of the ring buffer: ring pointers, counters, both ring memories
// and the output word register. Depends on utrb_pkg and utrb_ram.
module utrb_dpath
  import utrb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ctrl_cmd_t cmd_i,
  input  in_word_t  in_word_i,
  output out_word_t out_word_o
);

  in_word_t        item_q;
  out_word_t       out_word_q, out_word_d;
  logic [TxAw-1:0] tx_wr_ptr_q, tx_wr_ptr_d, tx_rd_ptr_q, tx_rd_ptr_d;
  logic [TxCw-1:0] tx_pending_q, tx_pending_d;
  logic [RxAw-1:0] rx_wr_ptr_q, rx_wr_ptr_d, rx_rd_ptr_q, rx_rd_ptr_d;
  logic [RxCw-1:0] rx_count_q, rx_count_d;
  logic            tx_wr_en, rx_wr_en;
  logic [7:0]      tx_rd_data, rx_rd_data;

  // Transmit ring.
  utrb_ram #(
    .Width(8),
    .Depth(TX_DEPTH)
  ) u_tx_ram (
    .clk_i    (clk_i),
    .wr_en_i  (tx_wr_en),
    .wr_addr_i(tx_wr_ptr_q),
    .wr_data_i(item_q.data_byte),
    .rd_en_i  (cmd_i.capture),
    .rd_addr_i(tx_rd_ptr_q),
    .rd_data_o(tx_rd_data)
  );

  // Receive ring.
  utrb_ram #(
    .Width(8),
    .Depth(RX_DEPTH)
  ) u_rx_ram (
    .clk_i    (clk_i),
    .wr_en_i  (rx_wr_en),
    .wr_addr_i(rx_wr_ptr_q),
    .wr_data_i(item_q.data_byte),
    .rd_en_i  (cmd_i.capture),
    .rd_addr_i(rx_rd_ptr_q),
    .rd_data_o(rx_rd_data)
  );

  // Event decode; the head entry of each ring was read when the word was taken.
  always_comb begin
    tx_wr_ptr_d  = tx_wr_ptr_q;
    tx_rd_ptr_d  = tx_rd_ptr_q;
    tx_pending_d = tx_pending_q;
    rx_wr_ptr_d  = rx_wr_ptr_q;
    rx_rd_ptr_d  = rx_rd_ptr_q;
    rx_count_d   = rx_count_q;
    tx_wr_en     = 1'b0;
    rx_wr_en     = 1'b0;
    out_word_d   = '{line_valid: 1'b0, line_byte: 8'h00, read_valid: 1'b0,
                     read_byte: 8'h00, status: ST_OK};
    case (item_q.mode)
      MODE_PUT: begin
        if (tx_pending_q == TxCw'(TX_DEPTH)) begin
          out_word_d.status = ST_TX_FULL;
        end else begin
          tx_pending_d = tx_pending_q + 1'b1;
          if (tx_pending_q == '0) begin
            // Idle line: the byte bypasses the ring.
            out_word_d.line_valid = 1'b1;
            out_word_d.line_byte  = item_q.data_byte;
          end else begin
            tx_wr_en    = cmd_i.commit;
            tx_wr_ptr_d = (tx_wr_ptr_q == TxAw'(TX_DEPTH - 1)) ? '0 :
                          tx_wr_ptr_q + 1'b1;
          end
        end
      end
      MODE_DONE: begin
        if (tx_pending_q != '0) begin
          tx_pending_d = tx_pending_q - 1'b1;
          if (tx_pending_q != TxCw'(1)) begin
            out_word_d.line_valid = 1'b1;
            out_word_d.line_byte  = tx_rd_data;
            tx_rd_ptr_d = (tx_rd_ptr_q == TxAw'(TX_DEPTH - 1)) ? '0 :
                          tx_rd_ptr_q + 1'b1;
          end
        end
      end
      MODE_RECV: begin
        if (rx_count_q == RxCw'(RX_DEPTH)) begin
          out_word_d.status = ST_RX_OVER;
        end else begin
          rx_count_d  = rx_count_q + 1'b1;
          rx_wr_en    = cmd_i.commit;
          rx_wr_ptr_d = (rx_wr_ptr_q == RxAw'(RX_DEPTH - 1)) ? '0 :
                        rx_wr_ptr_q + 1'b1;
        end
      end
      MODE_GET: begin
        if (rx_count_q == '0) begin
          out_word_d.read_byte = EMPTY_BYTE;
          out_word_d.status    = ST_RX_EMPTY;
        end else begin
          out_word_d.read_valid = 1'b1;
          out_word_d.read_byte  = rx_rd_data;
          rx_count_d  = rx_count_q - 1'b1;
          rx_rd_ptr_d = (rx_rd_ptr_q == RxAw'(RX_DEPTH - 1)) ? '0 :
                        rx_rd_ptr_q + 1'b1;
        end
      end
      default: begin
        out_word_d.status = ST_OK;
      end
    endcase
  end

  // Pointers and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_wr_ptr_q  <= '0;
      tx_rd_ptr_q  <= '0;
      tx_pending_q <= '0;
      rx_wr_ptr_q  <= '0;
      rx_rd_ptr_q  <= '0;
      rx_count_q   <= '0;
    end else if (cmd_i.commit) begin
      tx_wr_ptr_q  <= tx_wr_ptr_d;
      tx_rd_ptr_q  <= tx_rd_ptr_d;
      tx_pending_q <= tx_pending_d;
      rx_wr_ptr_q  <= rx_wr_ptr_d;
      rx_rd_ptr_q  <= rx_rd_ptr_d;
      rx_count_q   <= rx_count_d;
    end
  end

  // Input word and output word registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_word_i;
    end
    if (cmd_i.commit) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_word_o = out_word_q;

endmodule

// ===== hw/rtl/utrb_checker.sv =====
// Port-level checker for the UART ring buffer, bound to the top level.
// Depends on utrb_pkg.
module utrb_port_checker
  import utrb_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_i,
  input logic      out_valid_i,
  input logic      out_stall_i,
  input out_word_t out_word_i
);

  // A stalled output word stays valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i)
    else $error("output word dropped while stalled");

  // One word at a time: the cycle after an accept the input is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_i |=> in_stall_i)
    else $error("second word accepted while one is in work");

  // A word never both sends a line byte and returns a received byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(out_word_i.line_valid && out_word_i.read_valid))
    else $error("line and read results in one word");

  // Empty or rejected results carry no valid byte and an EMPTY_BYTE read byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_word_i.status != ST_OK |->
      !out_word_i.line_valid && !out_word_i.read_valid &&
      out_word_i.read_byte == EMPTY_BYTE)
    else $error("error status with data");

endmodule

bind uart_tx_rx_ring_buffer_top utrb_port_checker u_port_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_i (in_stall_o),
  .out_valid_i(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_word_i (out_word_o)
);

// ===== test/utrb_checker.sv =====
// Checker for the UART transmit/receive ring buffer: watches both channels,
// predicts each result word and compares it with what the block returns.
// Depends on utrb_pkg for the word types, event codes and ring sizes.
module utrb_checker
  import utrb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_word_t    in_word_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_word_t   out_word_i,
  output int unsigned mismatch_count_o,
  output int unsigned owed_count_o,
  output int unsigned checked_count_o,
  output int unsigned tx_full_hits_o,
  output int unsigned rx_over_hits_o,
  output int unsigned rx_empty_hits_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of both rings and their bookkeeping.
  logic [7:0]      tx_ring [TX_DEPTH];
  logic [TxAw-1:0] tx_wr_ptr;
  logic [TxAw-1:0] tx_rd_ptr;
  logic [TxCw-1:0] tx_pending;
  logic [7:0]      rx_ring [RX_DEPTH];
  logic [RxAw-1:0] rx_wr_ptr;
  logic [RxAw-1:0] rx_rd_ptr;
  logic [RxCw-1:0] rx_fill;

  // Result words still owed by the block, oldest first.
  out_word_t   owed_results [$];
  int unsigned mismatches = 0;
  int unsigned checked = 0;
  int unsigned tx_full_hits = 0;
  int unsigned rx_over_hits = 0;
  int unsigned rx_empty_hits = 0;

  // Applies one event word to the shadow rings and returns the result word.
  function automatic out_word_t apply_event(input in_word_t ev);
    out_word_t res;
    res = '0;
    res.status = ST_OK;
    case (ev.mode)
      MODE_PUT: begin
        if (tx_pending == TxCw'(TX_DEPTH)) begin
          res.status = ST_TX_FULL;
        end else begin
          tx_pending = tx_pending + 1'b1;
          // An idle transmit path sends the byte straight to the line.
          if (tx_pending == TxCw'(1)) begin
            res.line_valid = 1'b1;
            res.line_byte  = ev.data_byte;
          end else begin
            tx_ring[tx_wr_ptr] = ev.data_byte;
            tx_wr_ptr = (tx_wr_ptr == TxAw'(TX_DEPTH - 1)) ? '0 : tx_wr_ptr + 1'b1;
          end
        end
      end
      MODE_DONE: begin
        if (tx_pending != '0) begin
          tx_pending = tx_pending - 1'b1;
          // Hand the next queued byte to the line, unless that was the last.
          if (tx_pending != '0) begin
            res.line_valid = 1'b1;
            res.line_byte  = tx_ring[tx_rd_ptr];
            tx_rd_ptr = (tx_rd_ptr == TxAw'(TX_DEPTH - 1)) ? '0 : tx_rd_ptr + 1'b1;
          end
        end
      end
      MODE_RECV: begin
        if (rx_fill == RxCw'(RX_DEPTH)) begin
          res.status = ST_RX_OVER;
        end else begin
          rx_ring[rx_wr_ptr] = ev.data_byte;
          rx_wr_ptr = (rx_wr_ptr == RxAw'(RX_DEPTH - 1)) ? '0 : rx_wr_ptr + 1'b1;
          rx_fill = rx_fill + 1'b1;
        end
      end
      default: begin
        if (rx_fill == '0) begin
          res.read_byte = EMPTY_BYTE;
          res.status    = ST_RX_EMPTY;
        end else begin
          res.read_valid = 1'b1;
          res.read_byte  = rx_ring[rx_rd_ptr];
          rx_rd_ptr = (rx_rd_ptr == RxAw'(RX_DEPTH - 1)) ? '0 : rx_rd_ptr + 1'b1;
          rx_fill = rx_fill - 1'b1;
        end
      end
    endcase
    return res;
  endfunction

  // Compares a returned word with the oldest owed one.
  task automatic check_result(input out_word_t got);
    out_word_t want;
    if (owed_results.size() == 0) begin
      if (mismatches < 10) begin
        $display("%0t: result word with nothing owed: line %0b/%02h read %0b/%02h status %s",
                 $realtime, got.line_valid, got.line_byte, got.read_valid, got.read_byte,
                 got.status.name());
      end
      mismatches++;
    end else begin
      want = owed_results.pop_front();
      checked++;
      if (got.line_valid !== want.line_valid || got.line_byte !== want.line_byte ||
          got.read_valid !== want.read_valid || got.read_byte !== want.read_byte ||
          got.status !== want.status) begin
        if (mismatches < 10) begin
          $display("%0t: result word %0d wrong: expected line %0b/%02h read %0b/%02h %s",
                   $realtime, checked, want.line_valid, want.line_byte, want.read_valid,
                   want.read_byte, want.status.name());
          $display("%0t:   got line %0b/%02h read %0b/%02h %s", $realtime, got.line_valid,
                   got.line_byte, got.read_valid, got.read_byte, got.status.name());
        end
        mismatches++;
      end
    end
  endtask

  // Predict on every accepted event word, check on every accepted result word.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_wr_ptr  = '0;
      tx_rd_ptr  = '0;
      tx_pending = '0;
      rx_wr_ptr  = '0;
      rx_rd_ptr  = '0;
      rx_fill    = '0;
      owed_results.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        check_result(out_word_i);
      end
      if (in_valid_i && !in_stall_i) begin
        owed_results.push_back(apply_event(in_word_i));
        case (owed_results[$].status)
          ST_TX_FULL:  tx_full_hits++;
          ST_RX_OVER:  rx_over_hits++;
          ST_RX_EMPTY: rx_empty_hits++;
          default: ;
        endcase
      end
    end
    mismatch_count_o <= mismatches;
    owed_count_o     <= owed_results.size();
    checked_count_o  <= checked;
    tx_full_hits_o   <= tx_full_hits;
    rx_over_hits_o   <= rx_over_hits;
    rx_empty_hits_o  <= rx_empty_hits;
  end

endmodule

// ===== test/tb_uart_tx_rx_ring_buffer_top.sv =====
// Testbench top for the UART transmit/receive ring buffer: drives event words
// with random idling and stalls, and gives the verdict from utrb_checker.
// Depends on utrb_pkg, uart_tx_rx_ring_buffer_top and utrb_checker.
module tb_uart_tx_rx_ring_buffer_top;
  import utrb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomWords   = 500;
  localparam int unsigned QuietLimit    = 2000;
  localparam int unsigned DrainLimit    = 20000;
  localparam int unsigned TailCycles    = 8;

  // Kinds of random bursts; each but the mixed kind leans toward one side of one ring.
  typedef enum logic [2:0] {
    BURST_TX_FILL,
    BURST_TX_DRAIN,
    BURST_RX_FILL,
    BURST_RX_DRAIN,
    BURST_MIXED
  } burst_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_word_t    in_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_word;

  int unsigned idle_pct = 30;
  int unsigned stall_pct = 58;
  int unsigned quiet_cycles = 0;
  int unsigned words_sent = 0;

  int unsigned mismatch_count;
  int unsigned owed_count;
  int unsigned checked_count;
  int unsigned tx_full_hits;
  int unsigned rx_over_hits;
  int unsigned rx_empty_hits;

  always #10 clk_i = ~clk_i;

  uart_tx_rx_ring_buffer_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word)
  );

  utrb_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .in_word_i       (in_word),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .out_word_i      (out_word),
    .mismatch_count_o(mismatch_count),
    .owed_count_o    (owed_count),
    .checked_count_o (checked_count),
    .tx_full_hits_o  (tx_full_hits),
    .rx_over_hits_o  (rx_over_hits),
    .rx_empty_hits_o (rx_empty_hits)
  );

  // Random stall on the result side.
  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Ends the run when neither channel has moved a word for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("Watchdog: no word moved for %0d cycles", QuietLimit);
      $display("uart_tx_rx_ring_buffer_top test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one event word, after an optional random gap, until it is taken.
  task automatic send_word(input mode_e mode, input logic [7:0] data);
    in_word_t word;
    word.mode      = mode;
    word.data_byte = data;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_word  <= word;
    do @(posedge clk_i); while (in_stall);
    words_sent++;
  endtask

  // Random bursts of events with random bytes.
  task automatic run_bursts(input int unsigned count);
    int unsigned sent;
    int unsigned len;
    int unsigned roll;
    burst_e      kind;
    mode_e       mode;
    sent = 0;
    while (sent < count) begin
      kind = burst_e'($urandom_range(4));
      len  = $urandom_range(40, 1);
      repeat (len) begin
        roll = $urandom_range(99);
        case (kind)
          BURST_TX_FILL:  mode = (roll < 70) ? MODE_PUT : MODE_DONE;
          BURST_TX_DRAIN: mode = (roll < 70) ? MODE_DONE : MODE_PUT;
          BURST_RX_FILL:  mode = (roll < 70) ? MODE_RECV : MODE_GET;
          BURST_RX_DRAIN: mode = (roll < 70) ? MODE_GET : MODE_RECV;
          default:        mode = mode_e'($urandom_range(3));
        endcase
        send_word(mode, 8'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    int unsigned waited;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty get, idle done, bypass, queued bytes, last byte finished.
    send_word(MODE_GET, 8'hFF);
    send_word(MODE_DONE, 8'hFF);
    send_word(MODE_PUT, 8'h00);
    send_word(MODE_PUT, 8'hFF);
    send_word(MODE_PUT, 8'hA5);
    send_word(MODE_DONE, 8'h00);
    send_word(MODE_DONE, 8'h00);
    send_word(MODE_DONE, 8'h00);
    send_word(MODE_DONE, 8'h5A);
    send_word(MODE_RECV, 8'h00);
    send_word(MODE_RECV, 8'hFF);
    send_word(MODE_RECV, 8'h5A);
    send_word(MODE_GET, 8'h00);
    send_word(MODE_GET, 8'h00);
    send_word(MODE_GET, 8'h00);
    send_word(MODE_GET, 8'h00);

    // Fill the receive ring past full, then drain it past empty.
    repeat (RX_DEPTH + 1) send_word(MODE_RECV, 8'($urandom));
    repeat (RX_DEPTH + 1) send_word(MODE_GET, 8'($urandom));

    // Fill the transmit path until a put is rejected, then retire every byte.
    repeat (TX_DEPTH + 1) send_word(MODE_PUT, 8'($urandom));
    repeat (TX_DEPTH + 1) send_word(MODE_DONE, 8'($urandom));

    // Random traffic under three idling patterns.
    run_bursts(RandomWords / 3);
    idle_pct  = 58;
    stall_pct <= 30;
    run_bursts(RandomWords / 3);
    idle_pct  = 0;
    stall_pct <= 0;
    run_bursts(RandomWords - 2 * (RandomWords / 3));
    in_valid <= 1'b0;

    // Let every owed result arrive, then wait out the tail before the verdict.
    waited = 0;
    while (owed_count != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (TailCycles) @(posedge clk_i);

    $display("Run covered %0d event words and %0d checked results, with ring wraparound.",
             words_sent, checked_count);
    $display("Seen: %0d transmit-full rejects, %0d receive overflows, %0d empty gets.",
             tx_full_hits, rx_over_hits, rx_empty_hits);
    if (owed_count != 0) begin
      $display("%0d result words never arrived", owed_count);
    end
    if (mismatch_count == 0 && owed_count == 0) begin
      $display("uart_tx_rx_ring_buffer_top test passed");
    end else begin
      $display("uart_tx_rx_ring_buffer_top test failed");
    end
    $finish;
  end

endmodule
